// ----- hw/rtl/hpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

  localparam int unsigned NumRegs    = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned RegW       = 64;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned FracW      = 16;
  localparam int unsigned ProdW      = 2 * CoordW;
  localparam int unsigned SumW       = ProdW + 2;
  localparam int unsigned MagW       = ProdW;
  localparam int unsigned DivSteps   = CoordW;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned QCntW      = 3;

  localparam logic [CoordW-1:0] PosLimit = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] NegLimit = {1'b1, {(CoordW-1){1'b0}}};

  // Identity matrix, one half-register per coefficient.
  localparam logic [RegW-1:0] OneLow  = RegW'(64'h0000_0000_0001_0000);
  localparam logic [RegW-1:0] OneHigh = RegW'(64'h0001_0000_0000_0000);

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     zero_w;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } num_t;

  typedef struct packed {
    logic            zero_w;
    logic [MagW-1:0] den;
    num_t [2:0]      num;
  } job_t;

  typedef struct packed {
    logic [MagW-1:0]     rem;
    logic [CoordW-1:0]   q;
    logic [DivSteps-1:0] bits;
    logic                neg;
    logic                ovf;
  } lane_t;

  typedef struct packed {
    logic            zero_w;
    logic [MagW-1:0] den;
    lane_t [2:0]     lane;
  } stage_t;

  function automatic logic [RegW-1:0] reg_reset(input logic [CfgIdxW-1:0] idx);
    logic [RegW-1:0] v;
    unique case (idx)
      CfgIdxW'(0), CfgIdxW'(5): v = OneLow;
      CfgIdxW'(2), CfgIdxW'(7): v = OneHigh;
      default:                  v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/homogeneous_point_transform_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Homogeneous 4x4 point transform with perspective divide, Q16.16 in and out.
// Input channel: in_valid / in_stall / in_data carry one point (x, y, z); the
// point is taken as (x, y, z, 1) and multiplied by the configured matrix.
// Output channel: out_valid / out_stall / out_data carry x, y, z divided by w,
// truncated toward zero and saturated, plus zero_w and saturated flags.
// Configuration: cfg_write with cfg_index 0..7 loads one 64-bit register (two
// coefficients); write only while no point is in flight.
// Throughput: one point per cycle when nothing stalls. The divider is a
// 32-stage restoring divider (one quotient bit per stage, three lanes side
// by side).
// The front (multipliers, row sums) feeds a 4-entry queue; the back (divider,
// output register) drains it. When out_stall is high the back holds, the
// queue fills, and then in_stall rises.
// Reset (synchronous, rst high) loads the identity matrix and empties all
// pipeline stages and the queue.
module homogeneous_point_transform_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [hpt_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [hpt_pkg::RegW-1:0]     cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire hpt_pkg::point_t              in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output hpt_pkg::result_t                  out_data
);

  logic          q_push;
  hpt_pkg::job_t q_push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_head_valid;
  hpt_pkg::job_t q_head;

  hpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  hpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  hpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && !q_head_valid))
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue pushed while full");

  a_zero_w_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_w |->
      out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0 &&
      !out_data.saturated)
    else $error("zero divisor result not cleared");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

// ----- hw/rtl/hpt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpt_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [hpt_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [hpt_pkg::RegW-1:0]      cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire hpt_pkg::point_t               in_data,
  output logic                               push,
  output hpt_pkg::job_t                      push_data,
  input  wire logic                          full
);

  logic [hpt_pkg::RegW-1:0] cfg [hpt_pkg::NumRegs];
  logic signed [hpt_pkg::CoordW-1:0] coef [4][4];
  logic signed [hpt_pkg::CoordW-1:0] pt [3];

  logic                               v1;
  logic signed [hpt_pkg::ProdW-1:0]   prod [4][3];
  logic signed [hpt_pkg::CoordW-1:0]  trans [4];
  logic                               v2;
  logic signed [hpt_pkg::SumW-1:0]    sum [4];
  logic                               en;

  function automatic logic [hpt_pkg::MagW-1:0] mag_of(input logic signed [hpt_pkg::SumW-1:0] s);
    logic signed [hpt_pkg::SumW-1:0] a;
    a = s[hpt_pkg::SumW-1] ? -s : s;
    return a[hpt_pkg::MagW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NumRegs; i++) begin
        cfg[i] <= hpt_pkg::reg_reset(hpt_pkg::CfgIdxW'(i));
      end
    end else if (cfg_write) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (c % 2 == 1) begin
          coef[r][c] = $signed(cfg[2*r + c/2][hpt_pkg::RegW-1:hpt_pkg::CoordW]);
        end else begin
          coef[r][c] = $signed(cfg[2*r + c/2][hpt_pkg::CoordW-1:0]);
        end
      end
    end
  end

  assign pt[0] = in_data.point_x;
  assign pt[1] = in_data.point_y;
  assign pt[2] = in_data.point_z;

  assign en       = !v2 || !full;
  assign in_stall = !en;
  assign push     = v2 && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= coef[r][c] * pt[c];
        end
        trans[r] <= coef[r][3];
        // Translation column scales by 1.0 to line up with the Q32.32 products.
        sum[r] <= hpt_pkg::SumW'(prod[r][0]) + hpt_pkg::SumW'(prod[r][1])
                + hpt_pkg::SumW'(prod[r][2])
                + (hpt_pkg::SumW'(trans[r]) <<< hpt_pkg::FracW);
      end
    end
  end

  always_comb begin
    push_data.zero_w = (sum[3] == '0);
    push_data.den    = mag_of(sum[3]);
    for (int r = 0; r < 3; r++) begin
      push_data.num[r].neg = sum[r][hpt_pkg::SumW-1] ^ sum[3][hpt_pkg::SumW-1];
      push_data.num[r].mag = mag_of(sum[r]);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hpt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hpt_pkg::job_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output hpt_pkg::job_t       head
);

  hpt_pkg::job_t              mem [hpt_pkg::QueueDepth];
  logic [hpt_pkg::QPtrW-1:0]  wptr;
  logic [hpt_pkg::QPtrW-1:0]  rptr;
  logic [hpt_pkg::QCntW-1:0]  count;

  assign full       = (count == hpt_pkg::QCntW'(hpt_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hpt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpt_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire hpt_pkg::job_t     head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hpt_pkg::result_t       out_data
);

  hpt_pkg::stage_t st [hpt_pkg::DivSteps+1];
  logic            sv [hpt_pkg::DivSteps+1];
  logic            en;
  hpt_pkg::stage_t st0_next;
  hpt_pkg::result_t res_next;
  logic [hpt_pkg::CoordW-1:0] coord [3];
  logic [2:0]                 sat;

  function automatic hpt_pkg::lane_t div_step(input hpt_pkg::lane_t l,
                                              input logic [hpt_pkg::MagW-1:0] d);
    logic [hpt_pkg::MagW:0] t;
    logic                   ge;
    hpt_pkg::lane_t         o;
    t  = {l.rem, l.bits[hpt_pkg::DivSteps-1]};
    ge = (t >= {1'b0, d});
    o       = l;
    o.rem   = ge ? hpt_pkg::MagW'(t - {1'b0, d}) : t[hpt_pkg::MagW-1:0];
    o.q     = {l.q[hpt_pkg::CoordW-2:0], ge};
    o.bits  = {l.bits[hpt_pkg::DivSteps-2:0], 1'b0};
    return o;
  endfunction

  assign en  = !out_valid || !out_stall;
  assign pop = en && head_valid;

  always_comb begin
    st0_next.zero_w = head.zero_w;
    st0_next.den    = head.den;
    for (int r = 0; r < 3; r++) begin
      st0_next.lane[r].neg  = head.num[r].neg;
      // Quotient needs more than 32 bits when |num| << 16 >= den << 32.
      st0_next.lane[r].ovf  = ({16'b0, head.num[r].mag, 16'b0} >= {head.den, 32'b0});
      st0_next.lane[r].rem  = {16'b0, head.num[r].mag[hpt_pkg::MagW-1:hpt_pkg::FracW]};
      st0_next.lane[r].bits = {head.num[r].mag[hpt_pkg::FracW-1:0], 16'b0};
      st0_next.lane[r].q    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= hpt_pkg::DivSteps; k++) begin
        sv[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      sv[0] <= head_valid;
      for (int k = 0; k < hpt_pkg::DivSteps; k++) begin
        sv[k+1] <= sv[k];
      end
      out_valid <= sv[hpt_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_next;
    end
  end

  for (genvar k = 0; k < hpt_pkg::DivSteps; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].zero_w <= st[k].zero_w;
        st[k+1].den    <= st[k].den;
        for (int r = 0; r < 3; r++) begin
          st[k+1].lane[r] <= div_step(st[k].lane[r], st[k].den);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      logic [hpt_pkg::CoordW-1:0] lim;
      logic [hpt_pkg::CoordW-1:0] val;
      lim    = st[hpt_pkg::DivSteps].lane[r].neg ? hpt_pkg::NegLimit : hpt_pkg::PosLimit;
      sat[r] = st[hpt_pkg::DivSteps].lane[r].ovf || (st[hpt_pkg::DivSteps].lane[r].q > lim);
      val    = sat[r] ? lim : st[hpt_pkg::DivSteps].lane[r].q;
      coord[r] = st[hpt_pkg::DivSteps].lane[r].neg ? -val : val;
    end
    if (st[hpt_pkg::DivSteps].zero_w) begin
      res_next.out_x     = '0;
      res_next.out_y     = '0;
      res_next.out_z     = '0;
      res_next.zero_w    = 1'b1;
      res_next.saturated = 1'b0;
    end else begin
      res_next.out_x     = $signed(coord[0]);
      res_next.out_y     = $signed(coord[1]);
      res_next.out_z     = $signed(coord[2]);
      res_next.zero_w    = 1'b0;
      res_next.saturated = |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire
